@@ hw/rtl/assert_macros.svh @@
// Assertion macros for the checker file of the ranking block.
// Needs nothing else; include it by its bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is high.
`define PFR_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error(msg);

// Clocked assertion of the form "pre, then post in the next cycle".
`define PFR_ASSERT_NEXT(label, clk, rst, pre, post, msg) \
  `PFR_ASSERT(label, clk, rst, (pre) |=> (post), msg)

`endif

@@ hw/rtl/pfr_pkg.sv @@
// Package of the Pareto front ranking block: constants, state codes and the
// command and status structs between controller and datapath. No dependencies.
package pfr_pkg;

  localparam int DEF_MAX_POINTS = 64;
  localparam int DEF_MAX_DIMS   = 4;
  localparam int DEF_COORD_BITS = 32;

  localparam int IN_COORDS  = 4;
  localparam int IN_COORD_W = 32;
  localparam int RANK_W     = 7;
  localparam int PT_IDX_W   = 6;
  localparam int DIMS_W     = 3;

  localparam logic [DIMS_W-1:0] DIMS_RESET = 3'd2;

  localparam int APB_DATA_W = 32;
  localparam int APB_ADDR_W = 3;

  // Word index of each configuration register.
  localparam logic REG_DIMS_IN_USE = 1'b0;

  typedef enum logic [3:0] {
    S_LOAD,
    S_LVL,
    S_JRD,
    S_JCHK,
    S_KRD,
    S_KCMP,
    S_KDEC,
    S_LEND,
    S_ORD,
    S_OUT
  } pfr_state_t;

  typedef struct packed {
    logic load_pt;
    logic lvl_init;
    logic j_rd;
    logic j_step;
    logic k_first;
    logic k_rd;
    logic k_step;
    logic bump_k;
    logic bump_j;
    logic lvl_step;
    logic out_first;
    logic out_rd;
    logic out_step;
    logic set_done;
  } pfr_cmd_t;

  typedef struct packed {
    logic j_on_front;
    logic k_live;
    logic jk;
    logic kj;
    logic j_last;
    logic k_last;
    logic o_last;
    logic lvl_more;
  } pfr_status_t;

endpackage

@@ hw/rtl/pfr_point_if.sv @@
// Request channel that carries one point of the set into the ranking block.
// Depends on pfr_pkg for the field widths.
interface pfr_point_if;
  logic                            valid;
  logic                            ready;
  logic [pfr_pkg::IN_COORD_W-1:0]  coord_0;
  logic [pfr_pkg::IN_COORD_W-1:0]  coord_1;
  logic [pfr_pkg::IN_COORD_W-1:0]  coord_2;
  logic [pfr_pkg::IN_COORD_W-1:0]  coord_3;
  logic                            last_point;

  modport source (output valid, coord_0, coord_1, coord_2, coord_3, last_point,
                  input ready);
  modport sink (input valid, coord_0, coord_1, coord_2, coord_3, last_point,
                output ready);
endinterface

@@ hw/rtl/pfr_rank_if.sv @@
// Request channel that carries one ranked point out of the ranking block.
// Depends on pfr_pkg for the field widths.
interface pfr_rank_if;
  logic                          valid;
  logic                          ready;
  logic [pfr_pkg::PT_IDX_W-1:0]  point_index;
  logic [pfr_pkg::RANK_W-1:0]    front_rank;
  logic                          final_result;
  logic                          dropped_points;

  modport source (output valid, point_index, front_rank, final_result, dropped_points,
                  input ready);
  modport sink (input valid, point_index, front_rank, final_result, dropped_points,
                output ready);
endinterface

@@ hw/rtl/pareto_front_ranking_core.sv @@
// Top level of the Pareto front ranking block: channels, configuration
// register and the controller/datapath pair. Depends on pfr_pkg, the two
// channel interfaces, pfr_ctrl and pfr_dp.
//
//   channel   | dir | handshake     | carries
//   ----------+-----+---------------+------------------------------------------
//   points    | in  | valid/ready   | coord_0..coord_3, last_point
//   ranks     | out | valid/ready   | point_index, front_rank, final_result,
//             |     |               | dropped_points
//   APB       | in  | psel/penable  | dims_in_use at byte address 0
//
// Loading takes one point request per cycle. Each ranking level opens with a set-up
// state and closes with an end state; per point it reads and checks the rank, and per
// pairing with a candidate it reads memory, compares and decides; one level per front.
// Each result is a rank read, then an offer; a stalled result holds.
// Reset is synchronous with no clearing pass, as ranks are set to one while points
// load. Ranking and output block new points.
module pareto_front_ranking_core #(
  parameter int MAX_POINTS = pfr_pkg::DEF_MAX_POINTS,
  parameter int MAX_DIMS   = pfr_pkg::DEF_MAX_DIMS,
  parameter int COORD_BITS = pfr_pkg::DEF_COORD_BITS
) (
  input  logic                            clk,
  input  logic                            rst,
  pfr_point_if.sink                       points,
  pfr_rank_if.source                      ranks,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [pfr_pkg::APB_ADDR_W-1:0]  paddr,
  input  logic [pfr_pkg::APB_DATA_W-1:0]  pwdata,
  output logic [pfr_pkg::APB_DATA_W-1:0]  prdata,
  output logic                            pready
);

  pfr_pkg::pfr_cmd_t                              cmd;
  pfr_pkg::pfr_status_t                           st;
  logic [pfr_pkg::DIMS_W-1:0]                     dims_in_use;
  logic [pfr_pkg::IN_COORDS-1:0][pfr_pkg::IN_COORD_W-1:0] coords;
  logic                                           reg_sel;

  // The register file has a single word; bit 2 of the byte address picks it.
  assign reg_sel = (paddr[2] == pfr_pkg::REG_DIMS_IN_USE);
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      dims_in_use <= pfr_pkg::DIMS_RESET;
    end else if (psel && penable && pwrite && reg_sel) begin
      dims_in_use <= pwdata[pfr_pkg::DIMS_W-1:0];
    end
  end

  assign prdata = reg_sel ? pfr_pkg::APB_DATA_W'(dims_in_use) : '0;

  assign coords = {points.coord_3, points.coord_2, points.coord_1, points.coord_0};

  // The controller owns both handshakes; the datapath only follows commands.
  pfr_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (points.valid),
    .in_last   (points.last_point),
    .in_ready  (points.ready),
    .out_valid (ranks.valid),
    .out_ready (ranks.ready),
    .st        (st),
    .cmd       (cmd)
  );

  pfr_dp #(
    .MAX_POINTS (MAX_POINTS),
    .MAX_DIMS   (MAX_DIMS),
    .COORD_BITS (COORD_BITS)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .st             (st),
    .dims           (dims_in_use),
    .coords         (coords),
    .point_index    (ranks.point_index),
    .front_rank     (ranks.front_rank),
    .final_result   (ranks.final_result),
    .dropped_points (ranks.dropped_points)
  );

endmodule

@@ hw/rtl/pfr_ram.sv @@
// Generic RAM: one write port, two read ports with registered read data.
// No dependencies.
module pfr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  output logic [WIDTH-1:0]         rdata_a,
  input  logic                     re_b,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re_a) begin
      rdata_a <= mem[raddr_a];
    end
    if (re_b) begin
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

@@ hw/rtl/pfr_ctrl.sv @@
// Controller of the ranking block: load, level peeling and output sequencing.
// Depends on pfr_pkg for the state type and the command and status structs.
module pfr_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic                 in_last,
  output logic                 in_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  input  pfr_pkg::pfr_status_t st,
  output pfr_pkg::pfr_cmd_t    cmd
);

  pfr_pkg::pfr_state_t state;
  pfr_pkg::pfr_state_t state_next;
  logic                brk;

  // The current point is beaten by the candidate: it leaves the front.
  assign brk = st.k_live && !st.jk && st.kj;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pfr_pkg::S_LOAD;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      pfr_pkg::S_LOAD: begin
        if (in_valid && in_last) state_next = pfr_pkg::S_LVL;
      end
      pfr_pkg::S_LVL:  state_next = pfr_pkg::S_JRD;
      pfr_pkg::S_JRD:  state_next = pfr_pkg::S_JCHK;
      pfr_pkg::S_JCHK: begin
        if (st.j_on_front) state_next = pfr_pkg::S_KRD;
        else if (st.j_last) state_next = pfr_pkg::S_LEND;
        else state_next = pfr_pkg::S_JRD;
      end
      pfr_pkg::S_KRD:  state_next = pfr_pkg::S_KCMP;
      pfr_pkg::S_KCMP: state_next = pfr_pkg::S_KDEC;
      pfr_pkg::S_KDEC: begin
        if (brk || st.k_last) begin
          state_next = st.j_last ? pfr_pkg::S_LEND : pfr_pkg::S_JRD;
        end else begin
          state_next = pfr_pkg::S_KRD;
        end
      end
      pfr_pkg::S_LEND: state_next = st.lvl_more ? pfr_pkg::S_LVL : pfr_pkg::S_ORD;
      pfr_pkg::S_ORD:  state_next = pfr_pkg::S_OUT;
      pfr_pkg::S_OUT: begin
        if (out_ready) state_next = st.o_last ? pfr_pkg::S_LOAD : pfr_pkg::S_ORD;
      end
      default: state_next = pfr_pkg::S_LOAD;
    endcase
  end

  always_comb begin
    cmd       = '0;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    unique case (state)
      pfr_pkg::S_LOAD: begin
        in_ready    = 1'b1;
        cmd.load_pt = in_valid;
      end
      pfr_pkg::S_LVL:  cmd.lvl_init = 1'b1;
      pfr_pkg::S_JRD:  cmd.j_rd = 1'b1;
      pfr_pkg::S_JCHK: begin
        if (st.j_on_front) cmd.k_first = 1'b1;
        else if (!st.j_last) cmd.j_step = 1'b1;
      end
      pfr_pkg::S_KRD:  cmd.k_rd = 1'b1;
      pfr_pkg::S_KCMP: cmd = '0;
      pfr_pkg::S_KDEC: begin
        cmd.bump_k = st.k_live && st.jk && !st.kj;
        cmd.bump_j = brk;
        if (brk || st.k_last) begin
          cmd.j_step = !st.j_last;
        end else begin
          cmd.k_step = 1'b1;
        end
      end
      pfr_pkg::S_LEND: begin
        cmd.lvl_step  = 1'b1;
        cmd.out_first = !st.lvl_more;
      end
      pfr_pkg::S_ORD:  cmd.out_rd = 1'b1;
      pfr_pkg::S_OUT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          cmd.set_done = st.o_last;
          cmd.out_step = !st.o_last;
        end
      end
      default: cmd = '0;
    endcase
  end

endmodule

@@ hw/rtl/pfr_dp.sv @@
// Datapath of the ranking block: point and rank memories, pointers, level
// counter and the dominance compare. Depends on pfr_pkg and pfr_ram.
module pfr_dp #(
  parameter int MAX_POINTS = pfr_pkg::DEF_MAX_POINTS,
  parameter int MAX_DIMS   = pfr_pkg::DEF_MAX_DIMS,
  parameter int COORD_BITS = pfr_pkg::DEF_COORD_BITS
) (
  input  logic                                                 clk,
  input  logic                                                 rst,
  input  pfr_pkg::pfr_cmd_t                                    cmd,
  output pfr_pkg::pfr_status_t                                 st,
  input  logic [pfr_pkg::DIMS_W-1:0]                           dims,
  input  logic [pfr_pkg::IN_COORDS-1:0][pfr_pkg::IN_COORD_W-1:0] coords,
  output logic [pfr_pkg::PT_IDX_W-1:0]                         point_index,
  output logic [pfr_pkg::RANK_W-1:0]                           front_rank,
  output logic                                                 final_result,
  output logic                                                 dropped_points
);

  localparam int IDX_W = $clog2(MAX_POINTS);
  localparam int CNT_W = $clog2(MAX_POINTS + 1);
  localparam int LVL_W = $clog2(MAX_POINTS + 3);
  localparam int ROW_W = MAX_DIMS * COORD_BITS;

  logic [CNT_W-1:0]          count;
  logic                      overflow;
  logic [LVL_W-1:0]          level;
  logic                      changed;
  logic [IDX_W-1:0]          j;
  logic [IDX_W-1:0]          k;
  logic [IDX_W-1:0]          o;
  logic [MAX_DIMS-1:0]       gt_q;
  logic [MAX_DIMS-1:0]       lt_q;
  logic                      k_live_q;

  logic                      full;
  logic [IDX_W-1:0]          last_idx;
  logic [pfr_pkg::RANK_W-1:0] front;
  logic [pfr_pkg::DIMS_W-1:0] nd;
  logic [ROW_W-1:0]          row_wdata;
  logic [ROW_W-1:0]          row_a;
  logic [ROW_W-1:0]          row_b;
  logic [MAX_DIMS-1:0]       gt;
  logic [MAX_DIMS-1:0]       lt;
  logic                      store_pt;
  logic                      rank_we;
  logic [IDX_W-1:0]          rank_waddr;
  logic [pfr_pkg::RANK_W-1:0] rank_wdata;
  logic                      rank_re_a;
  logic [IDX_W-1:0]          rank_raddr_a;
  logic [pfr_pkg::RANK_W-1:0] rank_a;
  logic [pfr_pkg::RANK_W-1:0] rank_b;

  assign full     = (count == CNT_W'(MAX_POINTS));
  assign last_idx = IDX_W'(count - CNT_W'(1));
  assign front    = pfr_pkg::RANK_W'(level - LVL_W'(1));
  assign store_pt = cmd.load_pt && !full;

  // Zero dimensions compare as one; too many compare as all.
  always_comb begin
    priority if (dims == '0) begin
      nd = pfr_pkg::DIMS_W'(1);
    end else if (dims > pfr_pkg::DIMS_W'(MAX_DIMS)) begin
      nd = pfr_pkg::DIMS_W'(MAX_DIMS);
    end else begin
      nd = dims;
    end
  end

  for (genvar d = 0; d < MAX_DIMS; d++) begin : g_dim
    logic [2*pfr_pkg::IN_COORD_W-1:0] ext;
    logic signed [COORD_BITS-1:0]     ca;
    logic signed [COORD_BITS-1:0]     cb;
    logic                             used;

    assign ext = {{pfr_pkg::IN_COORD_W{coords[d][pfr_pkg::IN_COORD_W-1]}}, coords[d]};
    assign row_wdata[d*COORD_BITS +: COORD_BITS] = ext[COORD_BITS-1:0];
    assign ca   = row_a[d*COORD_BITS +: COORD_BITS];
    assign cb   = row_b[d*COORD_BITS +: COORD_BITS];
    assign used = (pfr_pkg::DIMS_W'(d) < nd);
    assign gt[d] = used && (ca > cb);
    assign lt[d] = used && (ca < cb);
  end

  pfr_ram #(
    .WIDTH (ROW_W),
    .DEPTH (MAX_POINTS)
  ) u_coord_ram (
    .clk     (clk),
    .we      (store_pt),
    .waddr   (count[IDX_W-1:0]),
    .wdata   (row_wdata),
    .re_a    (cmd.k_rd),
    .raddr_a (j),
    .rdata_a (row_a),
    .re_b    (cmd.k_rd),
    .raddr_b (k),
    .rdata_b (row_b)
  );

  always_comb begin
    rank_we    = store_pt || cmd.bump_k || cmd.bump_j;
    rank_waddr = count[IDX_W-1:0];
    rank_wdata = pfr_pkg::RANK_W'(1);
    priority if (cmd.bump_k) begin
      rank_waddr = k;
      rank_wdata = pfr_pkg::RANK_W'(level);
    end else if (cmd.bump_j) begin
      rank_waddr = j;
      rank_wdata = pfr_pkg::RANK_W'(level);
    end else begin
      rank_waddr = count[IDX_W-1:0];
      rank_wdata = pfr_pkg::RANK_W'(1);
    end
  end

  assign rank_re_a    = cmd.j_rd || cmd.out_rd;
  assign rank_raddr_a = cmd.out_rd ? o : j;

  pfr_ram #(
    .WIDTH (pfr_pkg::RANK_W),
    .DEPTH (MAX_POINTS)
  ) u_rank_ram (
    .clk     (clk),
    .we      (rank_we),
    .waddr   (rank_waddr),
    .wdata   (rank_wdata),
    .re_a    (rank_re_a),
    .raddr_a (rank_raddr_a),
    .rdata_a (rank_a),
    .re_b    (cmd.k_rd),
    .raddr_b (k),
    .rdata_b (rank_b)
  );

  // Compare flags are taken in the cycle after the rows come out of memory.
  always_ff @(posedge clk) begin
    gt_q     <= gt;
    lt_q     <= lt;
    k_live_q <= (k != j) && (rank_b == front);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      overflow <= 1'b0;
      level    <= LVL_W'(2);
      changed  <= 1'b0;
      j        <= '0;
      k        <= '0;
      o        <= '0;
    end else begin
      if (cmd.load_pt) begin
        if (full) overflow <= 1'b1;
        else count <= count + CNT_W'(1);
      end
      if (cmd.lvl_init) begin
        j       <= '0;
        changed <= 1'b0;
      end
      if (cmd.j_step) j <= j + IDX_W'(1);
      if (cmd.k_first) k <= '0;
      if (cmd.k_step) k <= k + IDX_W'(1);
      if (cmd.bump_k || cmd.bump_j) changed <= 1'b1;
      if (cmd.lvl_step) level <= level + LVL_W'(1);
      if (cmd.out_first) o <= '0;
      if (cmd.out_step) o <= o + IDX_W'(1);
      if (cmd.set_done) begin
        count    <= '0;
        overflow <= 1'b0;
        level    <= LVL_W'(2);
      end
    end
  end

  assign st.j_on_front = (rank_a == front);
  assign st.k_live     = k_live_q;
  assign st.jk         = ~|gt_q;
  assign st.kj         = ~|lt_q;
  assign st.j_last     = (j == last_idx);
  assign st.k_last     = (k == last_idx);
  assign st.o_last     = (o == last_idx);
  assign st.lvl_more   = changed && (level <= LVL_W'(MAX_POINTS));

  assign point_index    = pfr_pkg::PT_IDX_W'(o);
  assign front_rank     = rank_a;
  assign final_result   = (o == last_idx);
  assign dropped_points = overflow;

endmodule

@@ hw/rtl/pfr_checker.sv @@
// Port-level checks of the ranking block, bound to its top level.
// Depends on assert_macros.svh and pareto_front_ranking_core.
`include "assert_macros.svh"

module pfr_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic       in_last,
  input logic       out_valid,
  input logic       out_ready,
  input logic [5:0] out_index,
  input logic [6:0] out_rank,
  input logic       out_final,
  input logic       out_dropped
);

  // Loading and result delivery never overlap.
  `PFR_ASSERT(a_no_overlap, clk, rst, !(in_ready && out_valid), "load and output overlap")

  // A stalled result holds its value.
  `PFR_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready,
    out_valid && $stable(out_index) && $stable(out_rank) && $stable(out_final)
    && $stable(out_dropped), "stalled result changed")

  // Closing the set stops loading at once.
  `PFR_ASSERT_NEXT(a_last_closes, clk, rst, in_valid && in_ready && in_last,
    !in_ready, "point taken after the last point")

  // Taking the final result reopens loading in the next cycle.
  `PFR_ASSERT_NEXT(a_final_reopens, clk, rst, out_valid && out_ready && out_final,
    in_ready && !out_valid, "block not ready after final result")

endmodule

bind pareto_front_ranking_core pfr_checker u_pfr_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (points.valid),
  .in_ready    (points.ready),
  .in_last     (points.last_point),
  .out_valid   (ranks.valid),
  .out_ready   (ranks.ready),
  .out_index   (ranks.point_index),
  .out_rank    (ranks.front_rank),
  .out_final   (ranks.final_result),
  .out_dropped (ranks.dropped_points)
);
